FILE: rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// shared constants, codes and the record word type of the particle step core
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int FRACTION_BITS_DEF = 16;

	// opacity curve codes, unused codes act as linear
	localparam logic [2:0] CURVE_LINEAR   = 3'd0;
	localparam logic [2:0] CURVE_EASE_IN  = 3'd1;
	localparam logic [2:0] CURVE_EASE_OUT = 3'd2;
	localparam logic [2:0] CURVE_SMOOTH   = 3'd3;

	// tint mode codes, only gradient and rainbow change the color, every other code keeps the current color
	localparam logic [2:0] TINT_SOLID    = 3'd0;
	localparam logic [2:0] TINT_RANDOM   = 3'd1;
	localparam logic [2:0] TINT_GRADIENT = 3'd2;
	localparam logic [2:0] TINT_RAINBOW  = 3'd3;

	localparam logic [7:0] CHAN_FULL   = 8'hFF;
	localparam logic [2:0] SECTOR_LAST = 3'd5;

	typedef struct packed {
		logic [15:0] life;
		logic [7:0]  alpha_begin;
		logic [7:0]  alpha_finish;
		logic [2:0]  alpha_curve;
		logic [15:0] size_begin;
		logic [15:0] size_finish;
		logic [2:0]  tint_mode;
		logic [31:0] tint_begin;
		logic [31:0] tint_finish;
		logic [31:0] tint_now;
	} item_t;

endpackage

FILE: rtl/particle_life_gradient_step_core.sv
// ----------------------------------------------------------------------------
// particle_life_gradient_step_core
// ages one particle record a cycle and derives opacity, scale and color
// ----------------------------------------------------------------------------
// start passes the entry register, the divider stages and stages 2, 3 and 4 before done
// throughput: one word per cycle, busy is never raised
// the life/lifetime divider gives one quotient bit per stage and sets the depth
// the receiver cannot stall, every result shows on done for exactly one cycle
// reset clears all valid bits, nothing else needs clearing
module particle_life_gradient_step_core #(
	parameter int FRACTION_BITS = plc_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] life_left_in,
	input  logic [15:0] life_total,
	input  logic [15:0] elapsed_ms,
	input  logic [7:0]  alpha_begin,
	input  logic [7:0]  alpha_finish,
	input  logic [2:0]  alpha_curve,
	input  logic [15:0] size_begin,
	input  logic [15:0] size_finish,
	input  logic [2:0]  tint_mode,
	input  logic [31:0] tint_begin,
	input  logic [31:0] tint_finish,
	input  logic [31:0] tint_now,
	output logic        done,
	output logic [15:0] life_left_out,
	output logic [7:0]  alpha_out,
	output logic [15:0] size_out,
	output logic [31:0] tint_out,
	output logic        expired
);
	import plc_pkg::*;

	localparam int FB = FRACTION_BITS;
	localparam logic [FB:0]   ONE   = {1'b1, {FB{1'b0}}};
	localparam logic [FB+1:0] THREE = (FB+2)'(3) << FB;

	// no backpressure anywhere, a word can enter every cycle
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// entry stage and divider: index 0 is the entry register, stage i
	// resolves quotient bit FB-i of life/total
	// ------------------------------------------------------------------
	logic          dv_v_s    [0:FB];
	item_t         dv_it_s   [0:FB];
	logic [15:0]   dv_rem_s  [0:FB];
	logic [15:0]   dv_tot_s  [0:FB];
	logic [FB-1:0] dv_q_s    [0:FB];
	logic          dv_zero_s [0:FB];
	logic          dv_ge_s   [0:FB];

	logic [15:0] life_new;
	item_t       it_in;

	always_comb begin
		// remaining life floors at zero
		life_new = (elapsed_ms > life_left_in) ? 16'd0 : (life_left_in - elapsed_ms);
		it_in.life         = life_new;
		it_in.alpha_begin  = alpha_begin;
		it_in.alpha_finish = alpha_finish;
		it_in.alpha_curve  = alpha_curve;
		it_in.size_begin   = size_begin;
		it_in.size_finish  = size_finish;
		it_in.tint_mode    = tint_mode;
		it_in.tint_begin   = tint_begin;
		it_in.tint_finish  = tint_finish;
		it_in.tint_now     = tint_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		dv_it_s[0]   <= it_in;
		dv_rem_s[0]  <= life_new;
		dv_tot_s[0]  <= life_total;
		dv_q_s[0]    <= '0;
		// zero lifetime means progress one
		dv_zero_s[0] <= life_total == 16'd0;
		// life at or above lifetime saturates the ratio at one
		dv_ge_s[0]   <= life_new >= life_total;
	end

	for (genvar i = 1; i <= FB; i++) begin : g_div
		logic [16:0] rem2;
		logic        qbit;

		always_comb begin
			rem2 = {dv_rem_s[i-1], 1'b0};
			qbit = rem2 >= {1'b0, dv_tot_s[i-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[i] <= 1'b0;
			end else begin
				dv_v_s[i] <= dv_v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			dv_it_s[i]   <= dv_it_s[i-1];
			dv_tot_s[i]  <= dv_tot_s[i-1];
			dv_zero_s[i] <= dv_zero_s[i-1];
			dv_ge_s[i]   <= dv_ge_s[i-1];
			dv_rem_s[i]  <= qbit ? 16'(rem2 - {1'b0, dv_tot_s[i-1]}) : rem2[15:0];
			if (FB > 1) begin
				dv_q_s[i] <= FB'({dv_q_s[i-1], qbit});
			end else begin
				dv_q_s[i] <= FB'(qbit);
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 2: progress, squares for the curves, rainbow sector and ramp
	// ------------------------------------------------------------------
	logic [FB:0]       p_c;
	logic [FB:0]       q_c;
	logic [2*FB+1:0]   psq_c;
	logic [2*FB+1:0]   qsq_c;
	logic [FB+3:0]     h6_c;
	logic [2:0]        k_c;
	logic [FB+3:0]     f_c;
	logic [FB:0]       x_c;

	always_comb begin
		if (dv_zero_s[FB]) begin
			p_c = ONE;
		end else if (dv_ge_s[FB]) begin
			p_c = '0;
		end else begin
			p_c = ONE - {1'b0, dv_q_s[FB]};
		end
		q_c   = ONE - p_c;
		psq_c = (2*FB+2)'(p_c) * (2*FB+2)'(p_c);
		qsq_c = (2*FB+2)'(q_c) * (2*FB+2)'(q_c);
		// hue times six by shift and add
		h6_c  = {p_c, 2'b00} + {1'b0, p_c, 1'b0};
		k_c   = (h6_c[FB+3:FB] > 4'(SECTOR_LAST)) ? SECTOR_LAST : h6_c[FB+2:FB];
		f_c   = h6_c - {1'b0, k_c, {FB{1'b0}}};
		x_c   = k_c[0] ? (ONE - f_c[FB:0]) : f_c[FB:0];
	end

	logic          v_s2;
	item_t         it_s2;
	logic [FB:0]   p_s2;
	logic [FB:0]   sq_s2;
	logic [FB:0]   qq_s2;
	logic [2:0]    k_s2;
	logic [FB:0]   x_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= dv_v_s[FB];
		end
	end

	always_ff @(posedge clk) begin
		it_s2 <= dv_it_s[FB];
		p_s2  <= p_c;
		sq_s2 <= psq_c[2*FB:FB];
		qq_s2 <= qsq_c[2*FB:FB];
		k_s2  <= k_c;
		x_s2  <= x_c;
	end

	// ------------------------------------------------------------------
	// stage 3: eased opacity weight, rainbow ramp channel
	// ------------------------------------------------------------------
	logic [FB+1:0]   thr_c;
	logic [2*FB+2:0] sm_c;
	logic [FB:0]     eased_c;
	logic [FB+8:0]   x255_c;

	always_comb begin
		thr_c  = THREE - {p_s2, 1'b0};
		sm_c   = (2*FB+3)'(sq_s2) * (2*FB+3)'(thr_c);
		case (it_s2.alpha_curve)
			CURVE_EASE_IN:  eased_c = sq_s2;
			CURVE_EASE_OUT: eased_c = ONE - qq_s2;
			CURVE_SMOOTH:   eased_c = sm_c[2*FB:FB];
			default:        eased_c = p_s2;
		endcase
		x255_c = {x_s2, 8'd0} - (FB+9)'(x_s2);
	end

	logic          v_s3;
	item_t         it_s3;
	logic [FB:0]   p_s3;
	logic [FB:0]   eased_s3;
	logic [2:0]    k_s3;
	logic [7:0]    xc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		it_s3    <= it_s2;
		p_s3     <= p_s2;
		eased_s3 <= eased_c;
		k_s3     <= k_s2;
		xc_s3    <= x255_c[FB+7:FB];
	end

	// ------------------------------------------------------------------
	// stage 4: blends and color select into the result registers
	// ------------------------------------------------------------------
	logic [7:0]  alpha_c;
	logic [15:0] size_c;
	logic [31:0] grad_c;
	logic [31:0] rainbow_c;
	logic [31:0] tint_c;

	plc_blend #(.W(8), .FB(FB)) u_alpha (
		.start_val  (it_s3.alpha_begin),
		.finish_val (it_s3.alpha_finish),
		.t          (eased_s3),
		.res        (alpha_c)
	);

	plc_blend #(.W(16), .FB(FB)) u_size (
		.start_val  (it_s3.size_begin),
		.finish_val (it_s3.size_finish),
		.t          (p_s3),
		.res        (size_c)
	);

	// per ARGB channel gradient
	for (genvar c = 0; c < 4; c++) begin : g_chan
		plc_blend #(.W(8), .FB(FB)) u_chan (
			.start_val  (it_s3.tint_begin[8*c +: 8]),
			.finish_val (it_s3.tint_finish[8*c +: 8]),
			.t          (p_s3),
			.res        (grad_c[8*c +: 8])
		);
	end

	always_comb begin
		// hue sectors, alpha forced opaque
		case (k_s3)
			3'd0:    rainbow_c = {CHAN_FULL, CHAN_FULL, xc_s3, 8'd0};
			3'd1:    rainbow_c = {CHAN_FULL, xc_s3, CHAN_FULL, 8'd0};
			3'd2:    rainbow_c = {CHAN_FULL, 8'd0, CHAN_FULL, xc_s3};
			3'd3:    rainbow_c = {CHAN_FULL, 8'd0, xc_s3, CHAN_FULL};
			3'd4:    rainbow_c = {CHAN_FULL, xc_s3, 8'd0, CHAN_FULL};
			default: rainbow_c = {CHAN_FULL, CHAN_FULL, 8'd0, xc_s3};
		endcase
		case (it_s3.tint_mode)
			TINT_GRADIENT: tint_c = grad_c;
			TINT_RAINBOW:  tint_c = rainbow_c;
			default:       tint_c = it_s3.tint_now;
		endcase
	end

	logic v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		life_left_out <= it_s3.life;
		alpha_out     <= alpha_c;
		size_out      <= size_c;
		tint_out      <= tint_c;
		expired       <= it_s3.life == 16'd0;
	end

	assign done = v_s4;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> dv_v_s[0])
		else $error("accepted word did not enter the pipeline");

	a_prog: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (p_s2 <= ONE && x_s2 <= ONE))
		else $error("progress or hue ramp above one");

	a_eased: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> eased_s3 <= ONE)
		else $error("eased weight above one");

	a_exp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (expired == (life_left_out == 16'd0)))
		else $error("expired flag disagrees with remaining life");

endmodule

FILE: rtl/plc_blend.sv
// ----------------------------------------------------------------------------
// plc_blend
// start + (finish - start) * t, t in unsigned Q1.FB, truncated toward zero
// ----------------------------------------------------------------------------
module plc_blend #(
	parameter int W  = 8,
	parameter int FB = 16
) (
	input  logic [W-1:0]  start_val,
	input  logic [W-1:0]  finish_val,
	input  logic [FB:0]   t,
	output logic [W-1:0]  res
);
	logic           up;
	logic [W-1:0]   diff;
	logic [W+FB:0]  prod;
	logic [W+FB:0]  base;
	logic [W+FB:0]  num;

	always_comb begin
		up   = finish_val >= start_val;
		diff = up ? (finish_val - start_val) : (start_val - finish_val);
		prod = (W+FB+1)'(diff) * (W+FB+1)'(t);
		base = {1'b0, start_val, {FB{1'b0}}};
		num  = up ? (base + prod) : (base - prod);
		res  = num[FB +: W];
	end
endmodule

FILE: tb/particle_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_step_checker
// predicts each particle step from the accepted word and compares the result
// ----------------------------------------------------------------------------
module particle_step_checker #(
	parameter int FB = plc_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] life_left_in,
	input  logic [15:0] life_total,
	input  logic [15:0] elapsed_ms,
	input  logic [7:0]  alpha_begin,
	input  logic [7:0]  alpha_finish,
	input  logic [2:0]  alpha_curve,
	input  logic [15:0] size_begin,
	input  logic [15:0] size_finish,
	input  logic [2:0]  tint_mode,
	input  logic [31:0] tint_begin,
	input  logic [31:0] tint_finish,
	input  logic [31:0] tint_now,
	input  logic        done,
	input  logic [15:0] life_left_out,
	input  logic [7:0]  alpha_out,
	input  logic [15:0] size_out,
	input  logic [31:0] tint_out,
	input  logic        expired,
	output int          fail_count,
	output int          pending
);
	import plc_pkg::*;

	localparam logic [63:0] ONE = 64'd1 << FB;

	typedef struct packed {
		logic [15:0] life;
		logic [7:0]  alpha;
		logic [15:0] size;
		logic [31:0] tint;
		logic        expired;
	} step_t;

	step_t aged_q[$];

	function automatic logic [63:0] lerp(logic [63:0] a, logic [63:0] b, logic [63:0] t);
		logic [63:0] num;
		if (b >= a)
			num = a * ONE + (b - a) * t;
		else
			num = a * ONE - (a - b) * t;
		return num >> FB;
	endfunction

	function automatic logic [63:0] ease(logic [63:0] p, logic [2:0] curve);
		logic [63:0] q;
		logic [63:0] sq;
		case (curve)
			CURVE_EASE_IN: return (p * p) >> FB;
			CURVE_EASE_OUT: begin
				q = ONE - p;
				return ONE - ((q * q) >> FB);
			end
			CURVE_SMOOTH: begin
				sq = (p * p) >> FB;
				return (sq * (3 * ONE - 2 * p)) >> FB;
			end
			default: return p;
		endcase
	endfunction

	function automatic logic [31:0] hue(logic [63:0] p);
		logic [63:0] h6;
		logic [63:0] k;
		logic [63:0] f;
		logic [63:0] x;
		logic [7:0]  xc;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		h6 = p * 6;
		k = h6 >> FB;
		if (k > 64'(SECTOR_LAST))
			k = 64'(SECTOR_LAST);
		f = h6 - k * ONE;
		if (f > ONE)
			f = ONE;
		x = k[0] ? ONE - f : f;
		xc = 8'((x * 255) >> FB);
		r = 8'd0;
		g = 8'd0;
		b = 8'd0;
		case (k)
			0: begin r = CHAN_FULL; g = xc; end
			1: begin r = xc; g = CHAN_FULL; end
			2: begin g = CHAN_FULL; b = xc; end
			3: begin g = xc; b = CHAN_FULL; end
			4: begin r = xc; b = CHAN_FULL; end
			default: begin r = CHAN_FULL; b = xc; end
		endcase
		return {CHAN_FULL, r, g, b};
	endfunction

	function automatic step_t age_particle();
		step_t s;
		logic [63:0] life;
		logic [63:0] p;
		logic [63:0] ratio;
		logic [63:0] a;
		life = (elapsed_ms > life_left_in) ? 64'd0 : 64'(life_left_in - elapsed_ms);
		if (life_total == 16'd0)
			p = ONE;
		else begin
			ratio = (life << FB) / 64'(life_total);
			if (ratio > ONE)
				ratio = ONE;
			p = ONE - ratio;
		end
		a = lerp(64'(alpha_begin), 64'(alpha_finish), ease(p, alpha_curve));
		if (a > 64'd255)
			a = 64'd255;
		s.life = life[15:0];
		s.alpha = a[7:0];
		s.size = 16'(lerp(64'(size_begin), 64'(size_finish), p));
		s.expired = (life == 64'd0);
		if (tint_mode == TINT_GRADIENT)
			for (int i = 0; i < 32; i += 8)
				s.tint[i +: 8] = 8'(lerp(64'(tint_begin[i +: 8]),
					64'(tint_finish[i +: 8]), p));
		else if (tint_mode == TINT_RAINBOW)
			s.tint = hue(p);
		else
			s.tint = tint_now;
		return s;
	endfunction

	assign pending = aged_q.size();

	always @(posedge clk or negedge arst_n) begin
		step_t e;
		int    errs;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			errs = 0;
			if (start && !busy)
				aged_q.push_back(age_particle());
			if (done) begin
				if (aged_q.size() == 0) begin
					$error("result word with nothing expected");
					errs++;
				end else begin
					e = aged_q.pop_front();
					if (life_left_out !== e.life) begin
						$error("life_left_out exp %0h got %0h", e.life, life_left_out);
						errs++;
					end
					if (alpha_out !== e.alpha) begin
						$error("alpha_out exp %0h got %0h", e.alpha, alpha_out);
						errs++;
					end
					if (size_out !== e.size) begin
						$error("size_out exp %0h got %0h", e.size, size_out);
						errs++;
					end
					if (tint_out !== e.tint) begin
						$error("tint_out exp %0h got %0h", e.tint, tint_out);
						errs++;
					end
					if (expired !== e.expired) begin
						$error("expired exp %0b got %0b", e.expired, expired);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

FILE: tb/tb_particle_life_gradient_step_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_particle_life_gradient_step_core
// drives directed and random particle words into the step core with random
// start gaps, a checker beside the core predicts and compares every result
// ----------------------------------------------------------------------------
module tb_particle_life_gradient_step_core;
	import plc_pkg::*;

	localparam int N_RANDOM  = 900;
	localparam int LATENCY   = FRACTION_BITS_DEF + 4;
	localparam int WDOG_MAX  = 2000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] life_left_in;
	logic [15:0] life_total;
	logic [15:0] elapsed_ms;
	logic [7:0]  alpha_begin;
	logic [7:0]  alpha_finish;
	logic [2:0]  alpha_curve;
	logic [15:0] size_begin;
	logic [15:0] size_finish;
	logic [2:0]  tint_mode;
	logic [31:0] tint_begin;
	logic [31:0] tint_finish;
	logic [31:0] tint_now;
	logic        done;
	logic [15:0] life_left_out;
	logic [7:0]  alpha_out;
	logic [15:0] size_out;
	logic [31:0] tint_out;
	logic        expired;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;

	particle_life_gradient_step_core u_top (.*);

	particle_step_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: counts cycles with no word in or out
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("[particle_life_gradient_step_core] ERROR");
			$finish;
		end
	end

	// present one word and hold start until it is taken
	task automatic send_word(logic [15:0] life, logic [15:0] total, logic [15:0] dt,
			logic [7:0] a0, logic [7:0] a1, logic [2:0] curve,
			logic [15:0] s0, logic [15:0] s1, logic [2:0] mode,
			logic [31:0] c0, logic [31:0] c1, logic [31:0] cnow);
		start        <= 1'b1;
		life_left_in <= life;
		life_total   <= total;
		elapsed_ms   <= dt;
		alpha_begin  <= a0;
		alpha_finish <= a1;
		alpha_curve  <= curve;
		size_begin   <= s0;
		size_finish  <= s1;
		tint_mode    <= mode;
		tint_begin   <= c0;
		tint_finish  <= c1;
		tint_now     <= cnow;
		do @(posedge clk); while (busy);
	endtask

	// random word, mostly with life at or below the lifetime
	task automatic send_random();
		logic [15:0] total;
		logic [15:0] life;
		logic [15:0] dt;
		total = 16'($urandom());
		case ($urandom_range(0, 5))
			0: total = 16'd0;
			1: total = 16'($urandom_range(1, 16));
			default: ;
		endcase
		life = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
			16'($urandom_range(0, total));
		dt = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 64));
		send_word(life, total, dt, 8'($urandom()), 8'($urandom()), 3'($urandom()),
			16'($urandom()), 16'($urandom()), 3'($urandom()),
			$urandom(), $urandom(), $urandom());
	endtask

	initial begin
		int gap;
		arst_n       = 1'b0;
		start        = 1'b0;
		life_left_in = '0;
		life_total   = '0;
		elapsed_ms   = '0;
		alpha_begin  = '0;
		alpha_finish = '0;
		alpha_curve  = '0;
		size_begin   = '0;
		size_finish  = '0;
		tint_mode    = '0;
		tint_begin   = '0;
		tint_finish  = '0;
		tint_now     = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every curve and mode, special cases
		send_word(16'hFFFF, 16'hFFFF, 16'd0, 8'h00, 8'hFF, CURVE_LINEAR,
			16'h0000, 16'hFFFF, TINT_GRADIENT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678);
		// zero lifetime
		send_word(16'd100, 16'd0, 16'd10, 8'hFF, 8'h00, CURVE_EASE_IN,
			16'hFFFF, 16'h0000, TINT_RAINBOW, 32'hFFFF_FFFF, 32'h0, 32'h0);
		// life above lifetime
		send_word(16'hFFFF, 16'd100, 16'd1, 8'h10, 8'hF0, CURVE_EASE_OUT,
			16'h0100, 16'h0400, TINT_GRADIENT, 32'h80FF_0000, 32'h0000_FF80, 32'h0);
		// elapsed beyond life
		send_word(16'd5, 16'd1000, 16'hFFFF, 8'h33, 8'hCC, CURVE_SMOOTH,
			16'h0200, 16'h0080, TINT_SOLID, 32'h0, 32'h0, 32'hDEAD_BEEF);
		send_word(16'd0, 16'hFFFF, 16'd0, 8'hAA, 8'h55, 3'd4,
			16'h1234, 16'h4321, TINT_RANDOM, 32'h0, 32'h0, 32'hCAFE_F00D);
		for (int i = 0; i < 8; i++)
			send_word(16'(i * 125), 16'd1000, 16'd0, 8'h00, 8'hFF, 3'(i),
				16'h0000, 16'hFFFF, 3'(i), 32'h00FF_00FF, 32'hFF00_FF00, 32'h5A5A_A5A5);
		// rainbow across all sectors
		for (int i = 0; i < 7; i++)
			send_word(16'(600 - i * 100), 16'd600, 16'd0, 8'hFF, 8'h00, CURVE_SMOOTH,
				16'hFFFF, 16'h0001, TINT_RAINBOW, 32'h0, 32'h0, 32'h0);

		// random words with start gaps, gaps stop for the last stretch
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n < N_RANDOM - 100 && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 15);
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			send_random();
		end
		start <= 1'b0;

		// drain, then wait past the core latency for any stray word
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0)
			$display("[particle_life_gradient_step_core] OK");
		else
			$display("[particle_life_gradient_step_core] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/plc_pkg.sv
rtl/plc_blend.sv
rtl/particle_life_gradient_step_core.sv
tb/particle_step_checker.sv
tb/tb_particle_life_gradient_step_core.sv
